// File: rtl/rlpfe_pkg.sv
// Shared types, constants and helpers for the RGB LED PWM frame encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rlpfe_pkg;

    localparam int DATA_BITS   = 24;
    localparam int RESET_SLOTS = 80;
    localparam int FRAME_SLOTS = DATA_BITS + RESET_SLOTS;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int CH_W        = 8;
    localparam int DUTY_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(DATA_BITS);

    // item commands
    localparam logic CMD_SET_COLOR = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_RGB  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY  = CFG_IDX_W'(3);

    localparam logic [CH_W-1:0]   BRIGHTNESS_RST = 8'd255;
    localparam logic              ORDER_RGB_RST  = 1'b0;
    localparam logic [DUTY_W-1:0] ONE_DUTY_RST   = 16'd136;
    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST  = 16'd68;

    typedef struct packed {
        logic [CH_W-1:0]   brightness_level;
        logic              order_rgb;
        logic [DUTY_W-1:0] one_duty;
        logic [DUTY_W-1:0] zero_duty;
    } cfg_t;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } item_t;

    // round(c*b/255) == (c*b+127)/255 for 8-bit operands
    function automatic logic [CH_W-1:0] scale_channel(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] b
    );
        logic [2*CH_W:0] t;
        logic [2*CH_W:0] s;
        t = (2*CH_W+1)'(c * b) + (2*CH_W+1)'(128);
        s = t + (t >> CH_W);
        return s[2*CH_W-1:CH_W];
    endfunction

endpackage

// File: rtl/rgb_led_pwm_frame_encoder.sv
// Top level of the RGB LED PWM frame encoder: input register and handshakes.
// Depends on rlpfe_pkg, rlpfe_cfg_regs and rlpfe_frame_engine.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | cmd, red, green, blue
//  out     | out_valid / out_stall| duty, active, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while the result side is not stalled; a tick's
//  result passes through the input register, then the result register.
//  Set-color items produce no result. cfg_ready is always high.
//  out_stall holds the result register and stalls the input register;
//  the input side keeps accepting while the input register is empty.
//  rst_n clears all control state; the first frame after reset sends black.

module rgb_led_pwm_frame_encoder
    import rlpfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     duty,
    output logic                  active,
    output logic                  frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    item_t item_reg, item_next;
    logic  s1_valid_reg, s1_valid_next;
    logic  advance;
    logic  accept;

    assign cfg_ready = 1'b1;

    rlpfe_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        item_next     = item_reg;
        if (advance || !s1_valid_reg)
        begin
            s1_valid_next = in_valid;
        end
        if (accept)
        begin
            item_next.cmd   = cmd;
            item_next.red   = red;
            item_next.green = green;
            item_next.blue  = blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    rlpfe_frame_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .advance       (advance),
        .item_valid    (s1_valid_reg),
        .item          (item_reg),
        .res_valid     (out_valid),
        .res_duty      (duty),
        .res_active    (active),
        .res_frame_end (frame_end)
    );

endmodule

// File: rtl/rlpfe_cfg_regs.sv
// Configuration register file of the RGB LED PWM frame encoder.
// Depends on rlpfe_pkg.
`timescale 1ns / 1ps

module rlpfe_cfg_regs
    import rlpfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_BRIGHTNESS: cfg_next.brightness_level = wr_data[CH_W-1:0];
                REG_ORDER_RGB:  cfg_next.order_rgb        = wr_data[0];
                REG_ONE_DUTY:   cfg_next.one_duty         = wr_data[DUTY_W-1:0];
                REG_ZERO_DUTY:  cfg_next.zero_duty        = wr_data[DUTY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness_level <= BRIGHTNESS_RST;
            cfg_reg.order_rgb        <= ORDER_RGB_RST;
            cfg_reg.one_duty         <= ONE_DUTY_RST;
            cfg_reg.zero_duty        <= ZERO_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/rlpfe_frame_engine.sv
// Frame state, color scaling/packing, slot sequencing and the result register.
// Depends on rlpfe_pkg.
`timescale 1ns / 1ps

module rlpfe_frame_engine
    import rlpfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              advance,
    input  logic              item_valid,
    input  item_t             item,
    output logic              res_valid,
    output logic [DUTY_W-1:0] res_duty,
    output logic              res_active,
    output logic              res_frame_end
);

    logic [CH_W-1:0]      red_reg, red_next;
    logic [CH_W-1:0]      green_reg, green_next;
    logic [CH_W-1:0]      blue_reg, blue_next;
    logic                 pending_reg, pending_next;
    logic                 sending_reg, sending_next;
    logic [DATA_BITS-1:0] word_reg, word_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]    out_duty_reg, out_duty_next;
    logic                 out_active_reg, out_active_next;
    logic                 out_fend_reg, out_fend_next;

    logic                 step;
    logic                 tick;
    logic                 start;
    logic                 sending_now;
    logic                 last;
    logic [CH_W-1:0]      r_s, g_s, b_s;
    logic [DATA_BITS-1:0] word_start;
    logic [DATA_BITS-1:0] word_cur;
    logic [SLOT_W-1:0]    slot_cur;

    always_comb
    begin
        step  = advance && item_valid;
        tick  = step && (item.cmd == CMD_TICK);
        start = tick && !sending_reg && pending_reg;

        r_s = scale_channel(red_reg, cfg.brightness_level);
        g_s = scale_channel(green_reg, cfg.brightness_level);
        b_s = scale_channel(blue_reg, cfg.brightness_level);
        word_start = cfg.order_rgb ? {r_s, g_s, b_s} : {g_s, r_s, b_s};

        sending_now = sending_reg || start;
        word_cur    = start ? word_start : word_reg;
        slot_cur    = start ? '0 : slot_reg;
        last        = sending_now && (slot_cur >= LAST_SLOT);

        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        pending_next = pending_reg;
        sending_next = sending_reg;
        word_next    = word_reg;
        slot_next    = slot_reg;

        if (step && (item.cmd == CMD_SET_COLOR))
        begin
            red_next     = item.red;
            green_next   = item.green;
            blue_next    = item.blue;
            pending_next = 1'b1;
        end
        else if (tick)
        begin
            if (start)
            begin
                pending_next = 1'b0;
            end
            if (sending_now)
            begin
                // frame word shifts out MSB first
                word_next    = word_cur << 1;
                sending_next = !last;
                slot_next    = last ? '0 : slot_cur + SLOT_W'(1);
            end
        end

        out_valid_next  = out_valid_reg;
        out_duty_next   = out_duty_reg;
        out_active_next = out_active_reg;
        out_fend_next   = out_fend_reg;
        if (advance)
        begin
            out_valid_next  = tick;
            out_active_next = sending_now;
            out_fend_next   = last;
            if (sending_now && (slot_cur < DATA_END))
            begin
                out_duty_next = word_cur[DATA_BITS-1] ? cfg.one_duty : cfg.zero_duty;
            end
            else
            begin
                out_duty_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            pending_reg   <= 1'b1;
            sending_reg   <= 1'b0;
            word_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            pending_reg   <= pending_next;
            sending_reg   <= sending_next;
            word_reg      <= word_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_duty_reg   <= out_duty_next;
        out_active_reg <= out_active_next;
        out_fend_reg   <= out_fend_next;
    end

    assign res_valid     = out_valid_reg;
    assign res_duty      = out_duty_reg;
    assign res_active    = out_active_reg;
    assign res_frame_end = out_fend_reg;

endmodule

// File: verif/rlpfe_scoreboard_pkg.sv
// Slot predictor and result scoreboard for the RGB LED PWM frame encoder bench.
// Depends on rlpfe_pkg for widths, register indexes, reset values and item types.
`timescale 1ns / 1ps

package rlpfe_scoreboard_pkg;

    import rlpfe_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              active;
        logic              frame_end;
    } slot_result_t;

    class pwm_slot_scoreboard;
        cfg_t                 cfg;
        logic [CH_W-1:0]      color_r;
        logic [CH_W-1:0]      color_g;
        logic [CH_W-1:0]      color_b;
        bit                   refresh_pending;
        bit                   sending;
        logic [DATA_BITS-1:0] frame_bits;
        int unsigned          slot;
        slot_result_t         expected_slots[$];
        int unsigned          errors;

        function new();
            cfg.brightness_level = BRIGHTNESS_RST;
            cfg.order_rgb        = ORDER_RGB_RST;
            cfg.one_duty         = ONE_DUTY_RST;
            cfg.zero_duty        = ZERO_DUTY_RST;
            color_r         = '0;
            color_g         = '0;
            color_b         = '0;
            refresh_pending = 1'b1;   // black goes out first
            sending         = 1'b0;
            frame_bits      = '0;
            slot            = 0;
            errors          = 0;
        endfunction

        function logic [CH_W-1:0] scaled(logic [CH_W-1:0] c);
            int unsigned prod;
            prod = 32'(c) * 32'(cfg.brightness_level) + 32'd127;
            return CH_W'(prod / 32'd255);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_BRIGHTNESS: cfg.brightness_level = data[CH_W-1:0];
                REG_ORDER_RGB:  cfg.order_rgb        = data[0];
                REG_ONE_DUTY:   cfg.one_duty         = data[DUTY_W-1:0];
                REG_ZERO_DUTY:  cfg.zero_duty        = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(item_t it);
            logic [CH_W-1:0] r;
            logic [CH_W-1:0] g;
            logic [CH_W-1:0] b;
            slot_result_t    want;
            if (it.cmd == CMD_SET_COLOR)
            begin
                color_r         = it.red;
                color_g         = it.green;
                color_b         = it.blue;
                refresh_pending = 1'b1;
                return;
            end
            // brightness and order are latched only here, at frame start
            if (!sending && refresh_pending)
            begin
                r = scaled(color_r);
                g = scaled(color_g);
                b = scaled(color_b);
                frame_bits      = cfg.order_rgb ? {r, g, b} : {g, r, b};
                sending         = 1'b1;
                refresh_pending = 1'b0;
                slot            = 0;
            end
            want = '0;
            if (sending)
            begin
                want.active = 1'b1;
                if (slot < DATA_BITS)
                    want.duty = frame_bits[DATA_BITS-1-slot] ? cfg.one_duty : cfg.zero_duty;
                if (slot >= DATA_BITS + RESET_SLOTS - 1)
                begin
                    want.frame_end = 1'b1;
                    sending        = 1'b0;
                    slot           = 0;
                end
                else
                    slot++;
            end
            expected_slots.push_back(want);
        endfunction

        function void check_slot(logic [DUTY_W-1:0] duty, logic active, logic frame_end);
            slot_result_t want;
            if (expected_slots.size() == 0)
            begin
                $display("%0t: unexpected slot result duty %0d active %0b frame_end %0b",
                         $time, duty, active, frame_end);
                errors++;
                return;
            end
            want = expected_slots.pop_front();
            if (duty !== want.duty)
            begin
                $display("%0t: duty expected %0d got %0d", $time, want.duty, duty);
                errors++;
            end
            if (active !== want.active)
            begin
                $display("%0t: active expected %0b got %0b", $time, want.active, active);
                errors++;
            end
            if (frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                         frame_end);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_slots.size();
        endfunction
    endclass

endpackage

// File: verif/rgb_led_pwm_frame_encoder_tb.sv
// Top-level bench for the RGB LED PWM frame encoder: clock, reset, item and
// register drivers, random stalls and the monitor. Depends on rlpfe_pkg and
// rlpfe_scoreboard_pkg.
`timescale 1ns / 1ps

module rgb_led_pwm_frame_encoder_tb
    import rlpfe_pkg::*, rlpfe_scoreboard_pkg::*;
;

    localparam int HALF_PERIOD     = 6;      // 12 ns clock
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_CYCLES     = 250;
    localparam int SETTLE_CYCLES   = 4;      // two-stage pipe plus margin
    localparam int QUIET_LIMIT     = 3000;
    localparam int ITEMS_PER_PHASE = 115;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;
    logic                  out_valid;
    logic                  out_stall;
    logic [DUTY_W-1:0]     duty;
    logic                  active;
    logic                  frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pwm_slot_scoreboard sb = new();
    bit                 no_idle  = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        quiet    = 0;

    rgb_led_pwm_frame_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .duty      (duty),
        .active    (active),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (in_valid && !in_stall)
            sb.note_item({cmd, red, green, blue});
        if (out_valid && !out_stall)
            sb.check_slot(duty, active, frame_end);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("rgb_led_pwm_frame_encoder verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [CH_W-1:0] rand8();
        return CH_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand16();
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic send_item(input logic c, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b);
        in_valid <= 1'b1;
        cmd      <= c;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // gap of idle cycles, each drawn with the idle odds
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // color fields of a tick are don't-care, so they carry noise
    task automatic send_tick();
        send_item(CMD_TICK, rand8(), rand8(), rand8());
    endtask

    task automatic send_color(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        send_item(CMD_SET_COLOR, r, g, b);
    endtask

    task automatic run_ticks(input int count);
        repeat (count) send_tick();
    endtask

    task automatic run_phase(input int count, input int color_pct, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if ($urandom_range(99) < color_pct)
                send_color(rand8(), rand8(), rand8());
            else
                send_tick();
        end
    endtask

    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] bright,
                                input logic [CFG_DATA_W-1:0] order,
                                input logic [CFG_DATA_W-1:0] one,
                                input logic [CFG_DATA_W-1:0] zero,
                                input bit with_stray);
        wait_idle();
        if (with_stray)
        begin
            write_reg(REG_UNMAPPED_LO, rand16());
            write_reg(REG_UNMAPPED_HI, '1);
        end
        write_reg(REG_BRIGHTNESS, bright);
        write_reg(REG_ORDER_RGB, order);
        write_reg(REG_ONE_DUTY, one);
        write_reg(REG_ZERO_DUTY, zero);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_TICK;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first tick starts the black frame; colors set during it wait for its end,
        // the later one replacing the earlier; idle ticks follow the second frame
        send_tick();
        send_color(8'hFF, 8'h00, 8'hAA);
        send_color(8'h00, 8'hFF, 8'h55);
        run_ticks(2 * FRAME_SLOTS + 8);

        run_phase(ITEMS_PER_PHASE, 2, -1);

        // zero brightness through masking, RGB order, extreme duties, no idling
        program_regs(16'hFF00, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        no_idle = 1'b1;
        send_color(8'hFF, 8'hFF, 8'hFF);
        run_phase(ITEMS_PER_PHASE, 10, -1);

        program_regs(16'h00FF, 16'hFFFE, 16'h0000, 16'hFFFF, 1'b0);
        no_idle = 1'b0;
        send_color(8'h80, 8'h01, 8'hFE);
        run_phase(ITEMS_PER_PHASE, 30, 20);

        // minimum brightness: full channels round up to one, zero stays zero
        program_regs(16'h0001, 16'h0001, rand16(), rand16(), 1'b0);
        send_color(8'hFF, 8'h00, 8'hFF);
        run_phase(ITEMS_PER_PHASE, 0, -1);

        program_regs(rand16(), rand16(), rand16(), rand16(), 1'b1);
        run_phase(ITEMS_PER_PHASE, 5, -1);

        program_regs(16'h0080, rand16(), rand16(), rand16(), 1'b0);
        run_phase(ITEMS_PER_PHASE, 15, -1);

        wait_idle();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("rgb_led_pwm_frame_encoder verification clean");
        else
            $display("rgb_led_pwm_frame_encoder verification failed");
        $finish;
    end

endmodule
